### src/lcm5_pkg.sv
// ----------------------------------------------------------------------------
// lcm5_pkg
// Shared constants, status codes and controller/datapath interface types for
// the five-operand least common multiple block.
// ----------------------------------------------------------------------------
package lcm5_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int OPERAND_COUNT     = 5;
    localparam int ACC_W             = 64;
    localparam int IDX_W             = $clog2(OPERAND_COUNT);
    localparam int DIV_STEPS         = ACC_W;
    localparam int CNT_W             = $clog2(DIV_STEPS);
    localparam int STATUS_W          = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_ZERO = 2'd1;
    localparam status_t STATUS_OVF  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic             load;       // capture operands, acc <= first operand
        logic             mod_start;  // divider: acc / op[idx]
        logic             quo_start;  // divider: op[idx] / gcd
        logic             div_step;
        logic             gcd_start;
        logic             gcd_step;
        logic             mul_lo;
        logic             mul_hi;
        logic             mul_add;
        logic             publish;
        status_t          code;
        logic [IDX_W-1:0] idx;
    } lcm5_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic zero_seen;
        logic gcd_done;
        logic ovf;
        logic out_busy;
    } lcm5_stat_t;

endpackage

### src/lcm_of_five_unsigned.sv
// ----------------------------------------------------------------------------
// lcm_of_five_unsigned
// Least common multiple of five unsigned operands, saturating at 64 bits.
//
//   port group  dir  payload (low bits first)
//   s_*         in   tdata: first..fifth_value, OPERAND_WIDTH each, zero pad
//   m_*         out  tdata: multiple[63:0]; tuser: status[1:0]
//
// One item at a time. A zero operand skips the folds and goes straight to
// the result. Otherwise each of the four folds runs a full-width remainder
// divide, the binary GCD run and a short cofactor divide of OPERAND_WIDTH
// bits, then a two-half multiply; both divides use the one-bit-per-cycle
// restoring divider.
// Reset clears the sequencer and the output valid flag only.
// A result waiting on m_tready holds the sequencer at the end of the item.
// ----------------------------------------------------------------------------
module lcm_of_five_unsigned #(
    parameter int OPERAND_WIDTH = lcm5_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // first_value, second_value, third_value, fourth_value, fifth_value
    input  logic [((lcm5_pkg::OPERAND_COUNT*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // multiple
    output logic [lcm5_pkg::ACC_W-1:0]                    m_tdata,
    // status
    output lcm5_pkg::status_t                             m_tuser
);
    import lcm5_pkg::*;

    lcm5_cmd_t  cmd;
    lcm5_stat_t stat;

    lcm5_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcm5_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ops       (s_tdata[OPERAND_COUNT*OPERAND_WIDTH-1:0]),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_multiple (m_tdata),
        .out_status   (m_tuser)
    );

`ifndef SYNTH
    // the sequencer leaves idle on every accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice back to back");

    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_OVF) |-> (m_tdata == '1))
        else $error("overflow result not saturated");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_ZERO) |-> (m_tdata == '0))
        else $error("zero-operand result not cleared");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_OK) || (m_tuser == STATUS_ZERO)
                     || (m_tuser == STATUS_OVF))
        else $error("undefined status code");
`endif

endmodule

### src/lcm5_ctrl.sv
// ----------------------------------------------------------------------------
// lcm5_ctrl
// Sequencer: for each operand after the first runs remainder, binary GCD,
// cofactor divide and a two-half multiply, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lcm5_ctrl #(
    parameter int OPERAND_WIDTH = lcm5_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lcm5_pkg::lcm5_stat_t  stat,
    output lcm5_pkg::lcm5_cmd_t   cmd
);
    import lcm5_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_GINIT  = 4'd3;
    localparam logic [3:0] S_GCD    = 4'd4;
    localparam logic [3:0] S_QUO    = 4'd5;
    localparam logic [3:0] S_MLO    = 4'd6;
    localparam logic [3:0] S_MHI    = 4'd7;
    localparam logic [3:0] S_MADD   = 4'd8;
    localparam logic [3:0] S_NEXT   = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    status_t          code_reg, code_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = IDX_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.zero_seen)
                begin
                    code_next  = STATUS_ZERO;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_GINIT;
            end
            S_GINIT:
            begin
                cmd.gcd_start = 1'b1;
                state_next    = S_GCD;
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.quo_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_QUO;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_QUO:
            begin
                // short divide: only the operand's bits are shifted through
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(OPERAND_WIDTH - 1))
                    state_next = S_MLO;
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MADD;
            end
            S_MADD:
            begin
                cmd.mul_add = 1'b1;
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                if (stat.ovf)
                begin
                    code_next  = STATUS_OVF;
                    state_next = S_FINISH;
                end
                else if (idx_reg == IDX_W'(OPERAND_COUNT - 1))
                begin
                    code_next  = STATUS_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next      = idx_reg + IDX_W'(1);
                    cmd.idx       = idx_reg + IDX_W'(1);
                    cmd.mod_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_MOD;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            code_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            code_reg  <= code_next;
        end
    end

endmodule

### src/lcm5_dp.sv
// ----------------------------------------------------------------------------
// lcm5_dp
// Datapath: operand store, 64-bit accumulator, bit-serial restoring divider,
// binary GCD unit, shared 32x32 multiplier and the output register.
// ----------------------------------------------------------------------------
module lcm5_dp #(
    parameter int OPERAND_WIDTH = lcm5_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [lcm5_pkg::OPERAND_COUNT*OPERAND_WIDTH-1:0] in_ops,
    input  lcm5_pkg::lcm5_cmd_t                      cmd,
    output lcm5_pkg::lcm5_stat_t                     stat,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic [lcm5_pkg::ACC_W-1:0]               out_multiple,
    output lcm5_pkg::status_t                        out_status
);
    import lcm5_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W);

    logic [W-1:0]     ops_reg [OPERAND_COUNT];
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] dq_reg;       // dividend in, quotient out
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     div_reg;
    logic [W-1:0]     x_reg, y_reg;
    logic [KW-1:0]    k_reg;
    logic [ACC_W-1:0] pl_reg, ph_reg;
    logic             ovf_reg;
    logic             out_valid_reg;
    logic [ACC_W-1:0] out_data_reg;
    status_t          out_code_reg;

    logic [W-1:0]     b;
    logic [W-1:0]     g;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;
    logic [31:0]      mul_a, mul_b;
    logic [ACC_W-1:0] prod;
    logic [ACC_W:0]   sum;
    logic             zero_any;

    assign b = ops_reg[cmd.idx];
    assign g = W'(y_reg << k_reg);

    // restoring divider step
    assign trial = {rem_reg, dq_reg[ACC_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    assign mul_a = cmd.mul_hi ? acc_reg[ACC_W-1:32] : acc_reg[31:0];
    assign mul_b = 32'(dq_reg[W-1:0]);
    assign prod  = mul_a * mul_b;
    assign sum   = {1'b0, pl_reg} + {1'b0, ph_reg[31:0], 32'h0};

    always_comb
    begin
        zero_any = 1'b0;
        for (int i = 0; i < OPERAND_COUNT; i++)
            if (ops_reg[i] == '0)
                zero_any = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < OPERAND_COUNT; i++)
                ops_reg[i] <= in_ops[i*W +: W];
            acc_reg <= ACC_W'(in_ops[W-1:0]);
        end
        else if (cmd.mul_add)
            acc_reg <= sum[ACC_W-1:0];

        if (cmd.mod_start)
        begin
            dq_reg  <= acc_reg;
            rem_reg <= '0;
            div_reg <= b;
        end
        else if (cmd.quo_start)
        begin
            dq_reg  <= ACC_W'(b) << (ACC_W - W);
            rem_reg <= '0;
            div_reg <= g;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[ACC_W-2:0], fits};
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
        end

        // Stein's algorithm; x reaches zero with the odd part of the gcd in y
        if (cmd.gcd_start)
        begin
            x_reg <= rem_reg;
            y_reg <= b;
            k_reg <= '0;
        end
        else if (cmd.gcd_step)
        begin
            priority if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!x_reg[0])
                x_reg <= x_reg >> 1;
            else if (!y_reg[0])
                y_reg <= y_reg >> 1;
            else if (x_reg >= y_reg)
                x_reg <= x_reg - y_reg;
            else
                y_reg <= y_reg - x_reg;
        end

        if (cmd.mul_lo)
            pl_reg <= prod;
        if (cmd.mul_hi)
            ph_reg <= prod;
        if (cmd.mul_add)
            ovf_reg <= (ph_reg[ACC_W-1:32] != '0) || sum[ACC_W];

        if (cmd.publish)
        begin
            out_code_reg <= cmd.code;
            unique case (cmd.code)
                STATUS_OK:   out_data_reg <= acc_reg;
                STATUS_OVF:  out_data_reg <= '1;
                default:     out_data_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.zero_seen = zero_any;
    assign stat.gcd_done  = (x_reg == '0);
    assign stat.ovf       = ovf_reg;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign out_multiple = out_data_reg;
    assign out_status   = out_code_reg;

endmodule
